FILE: rtl/core/svte_pkg.sv
// Package for the scalar value tag encoder: value type codes, control byte
// codes, queue sizing and the descriptor passed from front to back.
// No dependencies.
package svte_pkg;

  typedef enum logic [2:0] {
    CMD_UNDEF  = 3'd0,
    CMD_NULL   = 3'd1,
    CMD_BOOL   = 3'd2,
    CMD_INT    = 3'd3,
    CMD_FLOAT  = 3'd4,
    CMD_DOUBLE = 3'd5,
    CMD_UNSPEC = 3'd6,
    CMD_RSVD   = 3'd7
  } svte_cmd_e;

  localparam logic [7:0] CTRL_UNDEF     = 8'h00;
  localparam logic [7:0] CTRL_NULL      = 8'h01;
  localparam logic [7:0] CTRL_FALSE     = 8'h02;
  localparam logic [7:0] CTRL_TRUE      = 8'h03;
  localparam logic [7:0] CTRL_UNSPEC    = 8'ha0;
  localparam logic [7:0] CTRL_SMALL_INT = 8'h10;
  localparam logic [7:0] CTRL_INT8      = 8'h1d;
  localparam logic [7:0] CTRL_INT16     = 8'h1c;
  localparam logic [7:0] CTRL_INT32     = 8'h1b;
  localparam logic [7:0] CTRL_VAR_POS   = 8'h1f;
  localparam logic [7:0] CTRL_VAR_NEG   = 8'h1e;
  localparam logic [7:0] CTRL_NAN       = 8'h20;
  localparam logic [7:0] CTRL_POS_INF   = 8'h2f;
  localparam logic [7:0] CTRL_NEG_INF   = 8'h2e;
  localparam logic [7:0] CTRL_FLOAT     = 8'h2d;
  localparam logic [7:0] CTRL_DOUBLE    = 8'h2c;

  localparam int unsigned VAR_GROUPS = 10;
  localparam int unsigned EXT_W      = 7 * VAR_GROUPS;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned PTR_W      = 1;
  localparam int unsigned CNT_W      = 2;

  // One encoding job: control byte, payload and its byte count.
  typedef struct packed {
    logic [7:0]  ctrl;
    logic [63:0] payload;
    logic [3:0]  nbytes;
    logic        varint;
  } svte_desc_t;

endpackage

FILE: rtl/core/scalar_value_tag_encoder_unit.sv
// Top level of the scalar value tag encoder.
// Depends on svte_pkg, svte_front, svte_fifo and svte_back.
//
// Input side: drive command_i and the value fields and raise push; the
// transaction completes at a clock edge with push high and full low.
// Command 7 is dropped without output.
// Output side: while empty is low, out_byte_o and last_o show the oldest
// byte; it is taken at an edge with pop high. last_o marks the final byte of
// one value's encoding.
// Each value yields 1 to 11 bytes (11 for the longest varint), and the output
// streams one byte per cycle while the receiver pops. When the block is
// idle, a value passes through the descriptor queue and then the output
// register before its first byte shows on the output.
// A two-entry descriptor queue sits between classification and the byte
// serializer, so the input keeps taking values while bytes are streaming.
// When the receiver stalls, the output register holds its byte, the
// serializer waits, the queue fills and full rises.
// Reset empties the queue and the output register.
module scalar_value_tag_encoder_unit import svte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic        bool_value_i,
  input  logic [63:0] int_value_i,
  input  logic [63:0] float_bits_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  svte_desc_t wr_desc;
  svte_desc_t rd_desc;
  logic       wr_en;
  logic       rd_en;
  logic       fifo_empty;

  svte_front u_front (
    .push         (push),
    .fifo_full_i  (full),
    .command_i    (command_i),
    .bool_value_i (bool_value_i),
    .int_value_i  (int_value_i),
    .float_bits_i (float_bits_i),
    .wr_en_o      (wr_en),
    .desc_o       (wr_desc)
  );

  svte_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_desc),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_desc),
    .full_o    (full),
    .empty_o   (fifo_empty)
  );

  svte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (rd_desc),
    .desc_empty_i (fifo_empty),
    .desc_pop_o   (rd_en),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

FILE: rtl/core/svte_front.sv
// Front part of the scalar value tag encoder: classifies an incoming value
// and builds the encoding descriptor. Depends on svte_pkg.
module svte_front import svte_pkg::*; (
  input  logic        push,
  input  logic        fifo_full_i,
  input  logic [2:0]  command_i,
  input  logic        bool_value_i,
  input  logic [63:0] int_value_i,
  input  logic [63:0] float_bits_i,
  output logic        wr_en_o,
  output svte_desc_t  desc_o
);

  logic               neg;
  logic               fits32;
  logic signed [31:0] s32;
  logic               tiny;
  logic               fits8;
  logic               fits16;
  logic               wide4;
  logic [63:0]        mag;
  logic [EXT_W-1:0]   ext;
  logic [VAR_GROUPS-1:0] grp_nz;
  logic [3:0]         grp_cnt;
  logic [31:0]        f32;
  logic               f_inf_nan;
  logic               f_mant_nz;
  logic               d_inf_nan;
  logic               d_mant_nz;
  svte_cmd_e          cmd;

  assign cmd     = svte_cmd_e'(command_i);
  assign wr_en_o = push && !fifo_full_i && (cmd != CMD_RSVD);

  assign neg    = int_value_i[63];
  assign fits32 = (int_value_i[63:32] == {32{int_value_i[31]}});
  assign s32    = $signed(int_value_i[31:0]);
  assign tiny   = !neg && (int_value_i[63:4] == 60'd0) && (int_value_i[3:0] <= 4'd10);
  assign fits8  = fits32 && (s32 >= -32'sd128) && (s32 <= 32'sd127);
  assign fits16 = fits32 && (s32 >= -32'sd32768) && (s32 <= 32'sd32767);
  assign wide4  = fits32 && ((s32 >= 32'sh0020_0000) || (s32 <= -32'sh0020_0000));
  assign mag    = neg ? (64'd0 - int_value_i) : int_value_i;
  assign ext    = {{(EXT_W-64){1'b0}}, mag};

  // The varint length is set by the highest nonzero 7-bit group.
  always_comb begin
    for (int g = 0; g < VAR_GROUPS; g++) begin
      grp_nz[g] = |ext[7*g +: 7];
    end
    grp_cnt = 4'd1;
    for (int g = 1; g < VAR_GROUPS; g++) begin
      if (grp_nz[g]) begin
        grp_cnt = 4'(g + 1);
      end
    end
  end

  assign f32       = float_bits_i[31:0];
  assign f_inf_nan = (f32[30:23] == 8'hff);
  assign f_mant_nz = |f32[22:0];
  assign d_inf_nan = (float_bits_i[62:52] == 11'h7ff);
  assign d_mant_nz = |float_bits_i[51:0];

  always_comb begin
    desc_o = '0;
    unique case (cmd)
      CMD_UNDEF:  desc_o.ctrl = CTRL_UNDEF;
      CMD_NULL:   desc_o.ctrl = CTRL_NULL;
      CMD_BOOL:   desc_o.ctrl = bool_value_i ? CTRL_TRUE : CTRL_FALSE;
      CMD_UNSPEC: desc_o.ctrl = CTRL_UNSPEC;
      CMD_INT: begin
        priority if (tiny) begin
          desc_o.ctrl = CTRL_SMALL_INT | {4'd0, int_value_i[3:0]};
        end else if (fits8) begin
          desc_o.ctrl    = CTRL_INT8;
          desc_o.payload = int_value_i;
          desc_o.nbytes  = 4'd1;
        end else if (fits16) begin
          desc_o.ctrl    = CTRL_INT16;
          desc_o.payload = int_value_i;
          desc_o.nbytes  = 4'd2;
        end else if (wide4) begin
          desc_o.ctrl    = CTRL_INT32;
          desc_o.payload = int_value_i;
          desc_o.nbytes  = 4'd4;
        end else begin
          desc_o.ctrl    = neg ? CTRL_VAR_NEG : CTRL_VAR_POS;
          desc_o.payload = mag;
          desc_o.nbytes  = grp_cnt;
          desc_o.varint  = 1'b1;
        end
      end
      CMD_FLOAT: begin
        if (f_inf_nan) begin
          desc_o.ctrl = f_mant_nz ? CTRL_NAN : (f32[31] ? CTRL_NEG_INF : CTRL_POS_INF);
        end else begin
          desc_o.ctrl    = CTRL_FLOAT;
          desc_o.payload = {32'd0, f32};
          desc_o.nbytes  = 4'd4;
        end
      end
      CMD_DOUBLE: begin
        if (d_inf_nan) begin
          desc_o.ctrl = d_mant_nz ? CTRL_NAN :
                        (float_bits_i[63] ? CTRL_NEG_INF : CTRL_POS_INF);
        end else begin
          desc_o.ctrl    = CTRL_DOUBLE;
          desc_o.payload = float_bits_i;
          desc_o.nbytes  = 4'd8;
        end
      end
      default: desc_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/svte_fifo.sv
// Short descriptor queue between front and back of the tag encoder.
// Depends on svte_pkg.
module svte_fifo import svte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  svte_desc_t wr_data_i,
  input  logic       rd_en_i,
  output svte_desc_t rd_data_o,
  output logic       full_o,
  output logic       empty_o
);

  svte_desc_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  assign full_o    = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (rd_en_i) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/core/svte_back.sv
// Back part of the tag encoder: serializes one descriptor into bytes,
// control byte first, through an output register. Depends on svte_pkg.
module svte_back import svte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  svte_desc_t desc_i,
  input  logic       desc_empty_i,
  output logic       desc_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic             busy_q, busy_d;
  logic [3:0]       idx_q, idx_d;
  logic [63:0]      payload_q, payload_d;
  logic             varint_q, varint_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             last_q, last_d;
  logic             out_ready;
  logic [3:0]       sel;
  logic [EXT_W-1:0] ext;
  logic [7:0]       pay_byte;

  assign out_ready  = !out_valid_q || pop;
  assign desc_pop_o = !busy_q && !desc_empty_i && out_ready;
  assign empty      = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign last_o     = last_q;

  // Payload bytes go out from the highest index down to index zero.
  assign sel = idx_q - 4'd1;
  assign ext = {{(EXT_W-64){1'b0}}, payload_q};
  always_comb begin
    if (varint_q) begin
      pay_byte = {(sel != 4'd0), ext[7*sel +: 7]};
    end else begin
      pay_byte = payload_q[8*sel[2:0] +: 8];
    end
  end

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    payload_d   = payload_q;
    varint_d    = varint_q;
    out_valid_d = out_valid_q && !pop;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    if (busy_q && out_ready) begin
      out_valid_d = 1'b1;
      out_byte_d  = pay_byte;
      last_d      = (idx_q == 4'd1);
      idx_d       = idx_q - 4'd1;
      busy_d      = (idx_q != 4'd1);
    end else if (desc_pop_o) begin
      out_valid_d = 1'b1;
      out_byte_d  = desc_i.ctrl;
      last_d      = (desc_i.nbytes == 4'd0);
      idx_d       = desc_i.nbytes;
      payload_d   = desc_i.payload;
      varint_d    = desc_i.varint;
      busy_d      = (desc_i.nbytes != 4'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q  <= payload_d;
    varint_q   <= varint_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

endmodule

FILE: rtl/core/svte_checker.sv
// Port-level checks for the scalar value tag encoder, bound to the top level.
// Depends on scalar_value_tag_encoder_unit.
module svte_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_o
);

  // A byte that is not taken stays on the output.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_o)))
    else $error("output byte changed while stalled");

  // Within one encoding the bytes follow each other without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_o) |=> !empty)
    else $error("gap inside an encoding");

  // The queue can only become full after an input transaction.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

endmodule

bind scalar_value_tag_encoder_unit svte_checker u_svte_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_byte_o (out_byte_o),
  .last_o     (last_o)
);
